// ----- rtl/core/krt_pkg.sv -----
// Shared types and constants for the keyed record table.
// No dependencies.
package krt_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_DELETE = 2'd1;
    localparam logic [1:0] KIND_UPDATE = 2'd2;
    localparam logic [1:0] KIND_LIST   = 2'd3;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_DUPLICATE = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND = 3'd2;
    localparam logic [2:0] ST_EMPTY     = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;

    // Datapath operations chosen by the controller
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,       // capture command
        OP_SCAN_RD,    // read entry at i
        OP_SCAN_CHK,   // compare read key with command key
        OP_APPEND,     // write command record at count
        OP_COMPACT,    // copy entry i to w if it does not match
        OP_UPDATE,     // overwrite entry i if it matches
        OP_SET_COUNT,  // count takes w plus hit
        OP_SORT_RDI,   // read entry i into slot a
        OP_SORT_RDJ,   // read entry j into slot b
        OP_SORT_WRI,   // write slot b at i, swap slots
        OP_SORT_WRJ,   // write slot b at j
        OP_EMIT_RD,    // read entry i for listing
        OP_RESULT      // load output register
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [IDX_W-1:0] i;
        logic [IDX_W-1:0] j;
        logic [IDX_W-1:0] w;
        logic [2:0]       status;
        logic             rec;    // result carries a record
        logic             last;
    } krt_cmd_t;

    typedef struct packed {
        logic [1:0]       kind;
        logic [CNT_W-1:0] count;
        logic             match;  // key matched during scan
        logic             hit;    // entry last checked matches; in compaction, it was kept
        logic             greater; // slot a key above slot b key
    } krt_stat_t;

endpackage

// ----- rtl/core/krt_datapath.sv -----
// Record memories, command registers, sort slots and the output register.
// Depends on krt_pkg.
module krt_datapath
    import krt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  krt_cmd_t          cmd,
    output krt_stat_t         stat,
    input  logic [1:0]        in_kind,
    input  logic [31:0]       in_key,
    input  logic [63:0]       in_name,
    input  logic [31:0]       in_price,
    output logic [2:0]        res_status,
    output logic [31:0]       res_key,
    output logic [63:0]       res_name,
    output logic [31:0]       res_price,
    output logic              res_last
);

    logic [31:0] key_mem   [CAPACITY];
    logic [63:0] name_mem  [CAPACITY];
    logic [31:0] price_mem [CAPACITY];

    logic [1:0]       kind_reg;
    logic [31:0]      key_reg;
    logic [63:0]      name_reg;
    logic [31:0]      price_reg;
    logic [CNT_W-1:0] count_reg;
    logic             match_reg;
    logic             hit_reg;
    logic [31:0]      rk_reg;
    logic [63:0]      rn_reg;
    logic [31:0]      rp_reg;
    logic [31:0]      ak_reg, bk_reg;
    logic [63:0]      an_reg, bn_reg;
    logic [31:0]      ap_reg, bp_reg;

    logic [IDX_W-1:0] rd_addr;

    assign stat.kind    = kind_reg;
    assign stat.count   = count_reg;
    assign stat.match   = match_reg;
    assign stat.hit     = hit_reg;
    assign stat.greater = $signed(ak_reg) > $signed(bk_reg);

    assign rd_addr = (cmd.op == OP_SORT_RDJ) ? cmd.j : cmd.i;

    // Registered memory read
    always_ff @(posedge clk)
    begin
        rk_reg <= key_mem[rd_addr];
        rn_reg <= name_mem[rd_addr];
        rp_reg <= price_mem[rd_addr];
    end

    // Single write port
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_APPEND:
            begin
                key_mem[count_reg[IDX_W-1:0]]   <= key_reg;
                name_mem[count_reg[IDX_W-1:0]]  <= name_reg;
                price_mem[count_reg[IDX_W-1:0]] <= price_reg;
            end
            OP_COMPACT:
            begin
                if (rk_reg != key_reg)
                begin
                    key_mem[cmd.w]   <= rk_reg;
                    name_mem[cmd.w]  <= rn_reg;
                    price_mem[cmd.w] <= rp_reg;
                end
            end
            OP_UPDATE:
            begin
                if (rk_reg == key_reg)
                begin
                    name_mem[cmd.i]  <= name_reg;
                    price_mem[cmd.i] <= price_reg;
                end
            end
            OP_SORT_WRI:
            begin
                key_mem[cmd.i]   <= bk_reg;
                name_mem[cmd.i]  <= bn_reg;
                price_mem[cmd.i] <= bp_reg;
            end
            OP_SORT_WRJ:
            begin
                key_mem[cmd.j]   <= bk_reg;
                name_mem[cmd.j]  <= bn_reg;
                price_mem[cmd.j] <= bp_reg;
            end
            default:
            begin
            end
        endcase
    end

    // Command capture, sort slots and results
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                kind_reg  <= in_kind;
                key_reg   <= in_key;
                name_reg  <= in_name;
                price_reg <= in_price;
            end
            OP_SORT_RDI:
            begin
                ak_reg <= rk_reg;
                an_reg <= rn_reg;
                ap_reg <= rp_reg;
            end
            OP_SORT_RDJ:
            begin
                bk_reg <= rk_reg;
                bn_reg <= rn_reg;
                bp_reg <= rp_reg;
            end
            OP_SORT_WRI:
            begin
                // after the swap slot a holds the new entry i
                ak_reg <= bk_reg;
                an_reg <= bn_reg;
                ap_reg <= bp_reg;
                bk_reg <= ak_reg;
                bn_reg <= an_reg;
                bp_reg <= ap_reg;
            end
            OP_RESULT:
            begin
                res_status <= cmd.status;
                res_last   <= cmd.last;
                res_key    <= cmd.rec ? rk_reg : key_reg;
                res_name   <= cmd.rec ? rn_reg : 64'd0;
                res_price  <= cmd.rec ? rp_reg : 32'd0;
            end
            default:
            begin
            end
        endcase
    end

    // Control-side registers: count and match flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            match_reg <= 1'b0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            case (cmd.op)
                OP_LOAD:
                    match_reg <= 1'b0;
                OP_SCAN_CHK:
                begin
                    hit_reg <= (rk_reg == key_reg);
                    if (rk_reg == key_reg)
                        match_reg <= 1'b1;
                end
                OP_APPEND:
                    count_reg <= count_reg + CNT_W'(1);
                OP_COMPACT:
                    hit_reg <= (rk_reg != key_reg);
                OP_SET_COUNT:
                    count_reg <= CNT_W'(cmd.w) + CNT_W'(hit_reg);
                default:
                begin
                end
            endcase
        end
    end

endmodule

// ----- rtl/core/krt_ctrl.sv -----
// Controller for the record table: scans, compaction, update, exchange sort, listing.
// Depends on krt_pkg.
module krt_ctrl
    import krt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_fire,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    output krt_cmd_t  cmd,
    input  krt_stat_t stat
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_DECIDE,
        S_WORK_RD,
        S_WORK,
        S_SRT_RI,
        S_SRT_RJ,
        S_SRT_CMP,
        S_SRT_WJ,
        S_EMIT_RD,
        S_EMIT_LD,
        S_OUT
    } state_t;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] i_reg, i_next, j_reg, j_next, w_reg, w_next;
    logic             ovalid_reg, ovalid_next;
    logic             more_reg, more_next;   // swap write at the old j still pending
    logic [2:0]       st_reg, st_next;
    logic             rec_reg, rec_next;
    logic             last_reg, last_next;
    logic [CNT_W-1:0] n1;

    assign n1        = stat.count - CNT_W'(1);
    assign in_ready  = (state_reg == S_IDLE) && !ovalid_reg;
    assign out_valid = ovalid_reg;

    always_comb
    begin
        state_next  = state_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        w_next      = w_reg;
        ovalid_next = ovalid_reg;
        more_next   = more_reg;
        st_next     = st_reg;
        rec_next    = rec_reg;
        last_next   = last_reg;
        cmd         = '0;
        cmd.op      = OP_NONE;
        cmd.i       = i_reg;
        cmd.j       = j_reg;
        cmd.w       = w_reg;
        cmd.status  = st_reg;
        cmd.rec     = rec_reg;
        cmd.last    = last_reg;

        if (ovalid_reg && out_ready)
            ovalid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    cmd.op     = OP_LOAD;
                    i_next     = '0;
                    state_next = S_SCAN_RD;
                end
            end
            S_SCAN_RD:
            begin
                if (stat.kind == KIND_LIST)
                begin
                    i_next = '0;
                    if (stat.count == '0)
                    begin
                        st_next = ST_EMPTY; rec_next = 1'b0; last_next = 1'b1;
                        more_next = 1'b0; state_next = S_OUT;
                    end
                    else if (stat.count == CNT_W'(1))
                        state_next = S_EMIT_RD;
                    else
                    begin
                        j_next = IDX_W'(1);
                        state_next = S_SRT_RI;
                    end
                end
                else if (CNT_W'(i_reg) >= stat.count)
                    state_next = S_DECIDE;
                else
                begin
                    cmd.op     = OP_SCAN_RD;
                    state_next = S_SCAN_CHK;
                end
            end
            S_SCAN_CHK:
            begin
                cmd.op = OP_SCAN_CHK;
                if (CNT_W'(i_reg) == n1)
                    state_next = S_DECIDE;
                else
                begin
                    i_next     = i_reg + IDX_W'(1);
                    state_next = S_SCAN_RD;
                end
            end
            S_DECIDE:
            begin
                rec_next = 1'b0; last_next = 1'b1; more_next = 1'b0;
                st_next = ST_OK; i_next = '0; w_next = '0;
                state_next = S_OUT;
                case (stat.kind)
                    KIND_INSERT:
                    begin
                        if (stat.match)
                            st_next = ST_DUPLICATE;
                        else if (stat.count == CNT_W'(CAPACITY))
                            st_next = ST_FULL;
                        else
                            cmd.op = OP_APPEND;
                    end
                    default:
                    begin
                        if (!stat.match)
                            st_next = ST_NOT_FOUND;
                        else
                            state_next = S_WORK_RD;
                    end
                endcase
            end
            S_WORK_RD:
            begin
                cmd.op     = OP_SCAN_RD;
                state_next = S_WORK;
                // hit now tells whether entry i-1 was kept
                if (stat.kind == KIND_DELETE && stat.hit && i_reg != '0)
                    w_next = w_reg + IDX_W'(1);
            end
            S_WORK:
            begin
                cmd.op = (stat.kind == KIND_DELETE) ? OP_COMPACT : OP_UPDATE;
                if (CNT_W'(i_reg) == n1)
                    state_next = (stat.kind == KIND_DELETE) ? S_EMIT_LD : S_OUT;
                else
                begin
                    i_next = i_reg + IDX_W'(1);
                    state_next = S_WORK_RD;
                end
            end
            // S_EMIT_LD doubles as count write-back after a delete
            S_SRT_RI:
            begin
                cmd.op = OP_SCAN_RD;
                state_next = S_SRT_RJ;
            end
            S_SRT_RJ:
            begin
                cmd.op = OP_SORT_RDI;
                cmd.i  = j_reg;
                state_next = S_SRT_CMP;
            end
            S_SRT_CMP:
            begin
                cmd.op = OP_SORT_RDJ;
                state_next = S_SRT_WJ;
            end
            S_SRT_WJ:
            begin
                if (stat.greater)
                    cmd.op = OP_SORT_WRI;
                state_next = S_SRT_RI;
                if (CNT_W'(j_reg) == n1)
                begin
                    if (CNT_W'(i_reg) + CNT_W'(2) == stat.count)
                    begin
                        i_next = '0;
                        state_next = S_EMIT_RD;
                    end
                    else
                    begin
                        i_next = i_reg + IDX_W'(1);
                        j_next = i_reg + IDX_W'(2);
                    end
                end
                else
                    j_next = j_reg + IDX_W'(1);
                if (stat.greater)
                    state_next = S_OUT;
                more_next = stat.greater;
            end
            S_EMIT_RD:
            begin
                cmd.op = OP_SCAN_RD;
                st_next = ST_OK; rec_next = 1'b1;
                last_next = (CNT_W'(i_reg) == n1);
                more_next = 1'b0;
                state_next = S_EMIT_LD;
            end
            S_EMIT_LD:
            begin
                if (stat.kind == KIND_DELETE)
                begin
                    cmd.op = OP_SET_COUNT;
                    state_next = S_OUT;
                end
                else if (!ovalid_reg || out_ready)
                begin
                    cmd.op      = OP_RESULT;
                    ovalid_next = 1'b1;
                    if (last_reg)
                        state_next = S_IDLE;
                    else
                    begin
                        i_next     = i_reg + IDX_W'(1);
                        state_next = S_EMIT_RD;
                    end
                end
            end
            S_OUT:
            begin
                if (more_reg)
                begin
                    // finish a swap: write old slot a at j
                    cmd.op = OP_SORT_WRJ;
                    cmd.j  = w_reg;
                    more_next = 1'b0;
                    state_next = S_SRT_RI;
                    if (i_reg == '0 && j_reg == '0)
                        state_next = S_EMIT_RD;
                end
                else if (!ovalid_reg || out_ready)
                begin
                    cmd.op      = OP_RESULT;
                    ovalid_next = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase

        // remember the old j for the deferred swap write
        if (state_reg == S_SRT_WJ)
            w_next = j_reg;
        if (state_reg == S_SRT_WJ && stat.greater
            && CNT_W'(j_reg) == n1 && CNT_W'(i_reg) + CNT_W'(2) == stat.count)
        begin
            i_next = '0;
            j_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            i_reg      <= '0;
            j_reg      <= '0;
            w_reg      <= '0;
            ovalid_reg <= 1'b0;
            more_reg   <= 1'b0;
            st_reg     <= ST_OK;
            rec_reg    <= 1'b0;
            last_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            i_reg      <= i_next;
            j_reg      <= j_next;
            w_reg      <= w_next;
            ovalid_reg <= ovalid_next;
            more_reg   <= more_next;
            st_reg     <= st_next;
            rec_reg    <= rec_next;
            last_reg   <= last_next;
        end
    end

endmodule

// ----- rtl/core/keyed_record_table_sorted_list_unit.sv -----
// Keyed record table with sorted listing, top level.
// Insert and unmatched commands: the result follows the key scan; matched delete and
// matched update make a second pass over the records (compaction or overwrite).
// List: an exchange sort by signed key, ascending, then one result per listed record.
// One command at a time; the next is taken once the last result has left.
// rst_n asynchronously empties the table; record memory contents are not cleared.
module keyed_record_table_sorted_list_unit
    import krt_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [31:0] item_key, [95:32] name_word, [127:96] price_cents
    input  logic [127:0] s_axis_tdata,
    // [1:0] kind
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [31:0] out_key, [95:32] out_name, [127:96] out_price
    output logic [127:0] m_axis_tdata,
    // [2:0] status
    output logic [2:0]   m_axis_tuser,
    output logic         m_axis_tlast
);

    krt_cmd_t    cmd;
    krt_stat_t   stat;
    logic [31:0] rkey, rprice;
    logic [63:0] rname;

    krt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (s_axis_tvalid && s_axis_tready),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd),
        .stat      (stat)
    );

    krt_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .in_kind    (s_axis_tuser),
        .in_key     (s_axis_tdata[31:0]),
        .in_name    (s_axis_tdata[95:32]),
        .in_price   (s_axis_tdata[127:96]),
        .res_status (m_axis_tuser),
        .res_key    (rkey),
        .res_name   (rname),
        .res_price  (rprice),
        .res_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {rprice, rname, rkey};

endmodule
